// ----- rtl/ordered_linear_probe_hash_table_assert.svh -----
// ----------------------------------------------------------------------------
// ordered linear probe hash table assertion macros
// concurrent assertion helpers used by the rtl
// ----------------------------------------------------------------------------
`ifndef ORDERED_LINEAR_PROBE_HASH_TABLE_ASSERT_SVH
`define ORDERED_LINEAR_PROBE_HASH_TABLE_ASSERT_SVH

// condition must hold at every clock edge outside reset
`define OLPH_ASSERT(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("olph assertion failed");

// antecedent implies consequent in the next cycle
`define OLPH_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("olph assertion failed");

`endif

// ----- rtl/olph_pkg.sv -----
// ----------------------------------------------------------------------------
// olph_pkg
// types and constants of the ordered linear probe hash table
// ----------------------------------------------------------------------------
`default_nettype none
package olph_pkg;

  localparam int SLOT_BITS   = 10;
  localparam int TABLE_SLOTS = 1 << SLOT_BITS;
  localparam int CNT_W       = SLOT_BITS + 1;
  localparam int KEY_W       = 32;
  localparam int VAL_W       = 32;
  localparam int MARK_W      = 2;
  localparam int ENTRY_W     = MARK_W + KEY_W + VAL_W;
  localparam int MISS_W      = 11;
  localparam int IVAL_W      = 11;
  localparam int CD_W        = 12;
  localparam int PADDR_W     = 3;
  localparam int PDATA_W     = 32;

  localparam logic [IVAL_W-1:0] IVAL_RESET = 11'd256;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_QUERY  = 2'd1;
  localparam logic [1:0] CMD_REMOVE = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_DUP     = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_MISSING = 2'd3;

  localparam logic [MARK_W-1:0] MARK_EMPTY = 2'd0;
  localparam logic [MARK_W-1:0] MARK_USED  = 2'd1;
  localparam logic [MARK_W-1:0] MARK_TOMB  = 2'd2;

  localparam logic [PADDR_W-1:0] ADDR_IVAL = 3'd0;

  typedef struct packed {
    logic [1:0]       cmd;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [VAL_W-1:0]  read_value;
    logic              rebuild_due;
    logic [MISS_W-1:0] probe_misses;
  } res_t;

  function automatic logic [SLOT_BITS-1:0] hash_of(input logic [KEY_W-1:0] k);
    return k[KEY_W-1 -: SLOT_BITS];
  endfunction

endpackage
`default_nettype wire

// ----- rtl/ordered_linear_probe_hash_table.sv -----
// flow: a request is taken in idle; a query, remove or non-full insert reads and evaluates
// each probed slot; a successful insert then searches for the cluster end, moves each
// record in the way up by one slot and writes the new record; the result waits on out_stall_i
// requests: one at a time, the next taken after the result; reset: a clearing pass marks
// every slot empty while no request is taken; configuration writes are accepted during it
// ----------------------------------------------------------------------------
// ordered_linear_probe_hash_table
// hash-ordered open addressing table with tombstones and rebuild countdown
// ----------------------------------------------------------------------------
`default_nettype none
module ordered_linear_probe_hash_table (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire olph_pkg::req_t                in_req_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output olph_pkg::res_t                     out_res_o,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [olph_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [olph_pkg::PDATA_W-1:0]  pwdata,
  output logic      [olph_pkg::PDATA_W-1:0]  prdata,
  output logic                               pready
);
  import olph_pkg::*;
  `include "ordered_linear_probe_hash_table_assert.svh"

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_PR_RD = 4'd2;
  localparam logic [3:0] S_PR_EV = 4'd3;
  localparam logic [3:0] S_SL_RD = 4'd4;
  localparam logic [3:0] S_SL_EV = 4'd5;
  localparam logic [3:0] S_EN_RD = 4'd6;
  localparam logic [3:0] S_EN_EV = 4'd7;
  localparam logic [3:0] S_CP_RD = 4'd8;
  localparam logic [3:0] S_CP_WR = 4'd9;
  localparam logic [3:0] S_FIN   = 4'd10;
  localparam logic [3:0] S_RES   = 4'd11;

  localparam logic [CNT_W-1:0] SLOTS_C = CNT_W'(TABLE_SLOTS);

  logic [3:0]            state_q, state_d;
  logic [SLOT_BITS-1:0]  clr_q, clr_d;
  req_t                  req_q, req_d;
  logic [SLOT_BITS-1:0]  h_q, h_d;
  logic [SLOT_BITS-1:0]  s_q, s_d;
  logic [SLOT_BITS-1:0]  end_q, end_d;
  logic [SLOT_BITS-1:0]  p_q, p_d;
  logic [CNT_W-1:0]      n_q, n_d;
  logic [CNT_W-1:0]      guard_q, guard_d;
  logic                  wrapped_q, wrapped_d;
  logic                  whinc_q, whinc_d;
  logic [1:0]            status_q, status_d;
  logic [VAL_W-1:0]      rv_q, rv_d;
  logic [SLOT_BITS-1:0]  wh_q, wh_d;
  logic [CNT_W-1:0]      rec_q, rec_d;
  logic [CNT_W-1:0]      tomb_q, tomb_d;
  logic signed [CD_W-1:0] cd_q, cd_d;
  logic [IVAL_W-1:0]     ival_q, ival_d;
  logic                  ovalid_q, ovalid_d;
  res_t                  ores_q, ores_d;

  logic                  we;
  logic [SLOT_BITS-1:0]  waddr, raddr;
  logic [ENTRY_W-1:0]    wdata, rdata;
  logic [MARK_W-1:0]     rmark;
  logic [KEY_W-1:0]      rkey;
  logic [VAL_W-1:0]      rval;
  logic                  ins, hit, stop_fwd;
  logic [SLOT_BITS-1:0]  hs, sn, q_prev;
  logic [CNT_W-1:0]      n_inc;
  logic                  cfg_wr, in_acc, out_acc;

  assign {rmark, rkey, rval} = rdata;
  assign ins    = (req_q.cmd == CMD_INSERT);
  assign hit    = (rmark == MARK_USED) && (rkey == req_q.key);
  assign hs     = hash_of(rkey);
  assign sn     = s_q + 1'b1;
  assign n_inc  = n_q + 1'b1;
  assign q_prev = p_q - 1'b1;
  assign stop_fwd = ins ? (hs >= h_q) : (hs > h_q);

  assign cfg_wr  = psel && penable && pwrite && (paddr == ADDR_IVAL);
  assign pready  = 1'b1;
  assign prdata  = (paddr == ADDR_IVAL) ? PDATA_W'(ival_q) : '0;
  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = ovalid_q;
  assign out_res_o   = ores_q;
  assign out_acc     = ovalid_q && !out_stall_i;

  olph_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_SLOTS)) u_slots (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    case (state_q)
      S_EN_RD: raddr = end_q;
      S_CP_RD: raddr = q_prev;
      default: raddr = s_q;
    endcase
  end

  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    req_d     = req_q;
    h_d       = h_q;
    s_d       = s_q;
    end_d     = end_q;
    p_d       = p_q;
    n_d       = n_q;
    guard_d   = guard_q;
    wrapped_d = wrapped_q;
    whinc_d   = whinc_q;
    status_d  = status_q;
    rv_d      = rv_q;
    wh_d      = wh_q;
    rec_d     = rec_q;
    tomb_d    = tomb_q;
    cd_d      = cd_q;
    ival_d    = ival_q;
    ovalid_d  = ovalid_q && !out_acc;
    ores_d    = ores_q;
    we        = 1'b0;
    waddr     = s_q;
    wdata     = {MARK_USED, req_q.key, req_q.value};

    case (state_q)
      S_CLEAR: begin
        we    = 1'b1;
        waddr = clr_q;
        wdata = {MARK_EMPTY, {(KEY_W + VAL_W){1'b0}}};
        clr_d = clr_q + 1'b1;
        if (clr_q == SLOT_BITS'(TABLE_SLOTS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          req_d     = in_req_i;
          h_d       = hash_of(in_req_i.key);
          s_d       = (hash_of(in_req_i.key) > wh_q) ? hash_of(in_req_i.key) : wh_q;
          n_d       = '0;
          wrapped_d = 1'b0;
          whinc_d   = 1'b0;
          rv_d      = '0;
          case (in_req_i.cmd)
            CMD_INSERT: begin
              if (rec_q >= SLOTS_C) begin
                status_d = ST_FULL;
                state_d  = S_RES;
              end else begin
                state_d = S_PR_RD;
              end
            end
            CMD_QUERY, CMD_REMOVE: state_d = S_PR_RD;
            default: begin
              status_d = ST_MISSING;
              state_d  = S_RES;
            end
          endcase
        end
      end
      S_PR_RD: state_d = S_PR_EV;
      S_PR_EV: begin
        if (hit) begin
          if (ins) begin
            status_d = ST_DUP;
            state_d  = S_RES;
          end else begin
            status_d = ST_OK;
            state_d  = S_RES;
            if (req_q.cmd == CMD_QUERY) begin
              rv_d = rval;
            end else begin
              we    = 1'b1;
              wdata = {MARK_TOMB, rkey, rval};
              if (tomb_q < SLOTS_C) tomb_d = tomb_q + 1'b1;
              if (rec_q != '0) rec_d = rec_q - 1'b1;
              if (cd_q != {1'b1, {(CD_W-1){1'b0}}}) cd_d = cd_q - 1'b1;
            end
          end
        end else if ((rmark == MARK_EMPTY) || ((rmark == MARK_USED) && stop_fwd)) begin
          status_d = ins ? ST_OK : ST_MISSING;
          state_d  = ins ? S_SL_RD : S_RES;
        end else begin
          s_d = sn;
          n_d = n_inc;
          if (sn == '0) wrapped_d = 1'b1;
          if ((sn == wh_q) || (n_inc > SLOTS_C)) begin
            status_d = ins ? ST_OK : ST_MISSING;
            state_d  = ins ? S_SL_RD : S_RES;
          end else begin
            state_d = S_PR_RD;
          end
        end
      end
      S_SL_RD: state_d = S_SL_EV;
      S_SL_EV: begin
        if (rmark != MARK_EMPTY) begin
          end_d   = sn;
          guard_d = CNT_W'(1);
          state_d = S_EN_RD;
        end else begin
          whinc_d = wrapped_q && (s_q == wh_q);
          state_d = S_FIN;
        end
      end
      S_EN_RD: state_d = S_EN_EV;
      S_EN_EV: begin
        if ((rmark == MARK_USED) && (guard_q <= SLOTS_C)) begin
          end_d   = end_q + 1'b1;
          guard_d = guard_q + 1'b1;
          state_d = S_EN_RD;
        end else begin
          if ((rmark == MARK_TOMB) && (tomb_q != '0)) tomb_d = tomb_q - 1'b1;
          whinc_d = ((end_q < s_q) || wrapped_q) && (end_q >= wh_q);
          p_d     = end_q;
          state_d = (end_q == s_q) ? S_FIN : S_CP_RD;
        end
      end
      S_CP_RD: state_d = S_CP_WR;
      S_CP_WR: begin
        we      = 1'b1;
        waddr   = p_q;
        wdata   = rdata;
        p_d     = q_prev;
        state_d = (q_prev == s_q) ? S_FIN : S_CP_RD;
      end
      S_FIN: begin
        we    = 1'b1;
        rec_d = rec_q + 1'b1;
        if (whinc_q) wh_d = wh_q + 1'b1;
        if (cd_q != {1'b1, {(CD_W-1){1'b0}}}) cd_d = cd_q - 1'b1;
        state_d = S_RES;
      end
      S_RES: begin
        if (!ovalid_q || out_acc) begin
          ovalid_d            = 1'b1;
          ores_d.status       = status_q;
          ores_d.read_value   = rv_q;
          ores_d.rebuild_due  = (cd_q <= 0);
          ores_d.probe_misses = MISS_W'(n_q);
          state_d             = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (cfg_wr) begin
      ival_d = pwdata[IVAL_W-1:0];
      cd_d   = signed'(CD_W'(pwdata[IVAL_W-1:0]));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      clr_q    <= '0;
      wh_q     <= '0;
      rec_q    <= '0;
      tomb_q   <= '0;
      ival_q   <= IVAL_RESET;
      cd_q     <= signed'(CD_W'(IVAL_RESET));
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      wh_q     <= wh_d;
      rec_q    <= rec_d;
      tomb_q   <= tomb_d;
      ival_q   <= ival_d;
      cd_q     <= cd_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q     <= req_d;
    h_q       <= h_d;
    s_q       <= s_d;
    end_q     <= end_d;
    p_q       <= p_d;
    n_q       <= n_d;
    guard_q   <= guard_d;
    wrapped_q <= wrapped_d;
    whinc_q   <= whinc_d;
    status_q  <= status_d;
    rv_q      <= rv_d;
    ores_q    <= ores_d;
  end

  `OLPH_ASSERT(a_rec_bound, clk_i, rst_ni, rec_q <= SLOTS_C)
  `OLPH_ASSERT(a_tomb_bound, clk_i, rst_ni, tomb_q <= SLOTS_C)
  `OLPH_ASSERT_NEXT(a_clear_no_out, clk_i, rst_ni, state_q == S_CLEAR, !ovalid_q)
  `OLPH_ASSERT_NEXT(a_acc_probe, clk_i, rst_ni, in_acc, state_q != S_IDLE)

endmodule
`default_nettype wire

// ----- rtl/olph_ram.sv -----
// ----------------------------------------------------------------------------
// olph_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none
module olph_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire
